// ----- rtl/uart_rx_tx_ring_buffers_unit_defines.svh -----
// assertion macros shared by the uart ring buffer unit
`ifndef UART_RX_TX_RING_BUFFERS_UNIT_DEFINES_SVH
`define UART_RX_TX_RING_BUFFERS_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define URTRB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define URTRB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/urtrb_pkg.sv -----
// shared types and request codes of the uart ring buffer unit
package urtrb_pkg;

  // request kinds
  localparam logic [1:0] REQ_LINE_RX  = 2'd0;
  localparam logic [1:0] REQ_TX_READY = 2'd1;
  localparam logic [1:0] REQ_GET      = 2'd2;
  localparam logic [1:0] REQ_PUT      = 2'd3;

  typedef logic [7:0] byte_t;

  // controller to datapath commands
  typedef struct packed {
    logic take;
    logic emit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_full;
  } status_t;

endpackage

// ----- rtl/urtrb_channels.sv -----
// request and result channel interfaces of the uart ring buffer unit

// request channel
interface urtrb_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  urtrb_pkg::byte_t   data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

// result channel
interface urtrb_rsp_if;
  logic               valid;
  logic               ready;
  logic               line_valid;
  urtrb_pkg::byte_t   line_byte;
  urtrb_pkg::byte_t   read_byte;
  logic               rx_dropped;
  logic               put_discarded;
  logic               tx_enabled;

  modport source (output valid, output line_valid, output line_byte, output read_byte,
                  output rx_dropped, output put_discarded, output tx_enabled,
                  input ready);
  modport sink   (input valid, input line_valid, input line_byte, input read_byte,
                  input rx_dropped, input put_discarded, input tx_enabled,
                  output ready);
endinterface

// ----- rtl/urtrb_ctrl.sv -----
// sequencing state machine of the uart ring buffer unit
module urtrb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic               rsp_ready,
  input  urtrb_pkg::status_t status,
  output urtrb_pkg::cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_free;

  // output register can take a new result this cycle
  assign out_free = !status.out_full || rsp_ready;

  // commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/urtrb_dp.sv -----
// queue memories, pointers and result register of the uart ring buffer unit
module urtrb_dp #(
  parameter int QUEUE_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  urtrb_pkg::cmd_t    cmd,
  output urtrb_pkg::status_t status,
  input  logic [1:0]         req_type,
  input  urtrb_pkg::byte_t   data_byte,
  input  logic               rsp_ready,
  output logic               rsp_valid,
  output logic               line_valid,
  output urtrb_pkg::byte_t   line_byte,
  output urtrb_pkg::byte_t   read_byte,
  output logic               rx_dropped,
  output logic               put_discarded,
  output logic               tx_enabled
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

  urtrb_pkg::byte_t rx_mem [QUEUE_DEPTH];
  urtrb_pkg::byte_t tx_mem [QUEUE_DEPTH];

  logic [PTR_W-1:0] rx_wp, rx_rp, tx_wp, tx_rp;
  logic [PTR_W-1:0] rx_wp_next, rx_rp_next, tx_wp_next, tx_rp_next;
  logic             tx_en, discard;
  logic             tx_en_next, discard_next;
  logic             rx_full, rx_empty, tx_full, tx_empty;
  logic             rx_push, rx_pop, tx_push, tx_pop, drop, pdisc;

  // item results held between take and emit
  urtrb_pkg::byte_t rx_rd, tx_rd;
  logic             pop_line, pop_get, drop_r, pdisc_r, tx_en_r;
  logic             out_full;

  // wrap-around successors and fill state
  assign rx_wp_next = (rx_wp == LAST) ? '0 : rx_wp + 1'b1;
  assign rx_rp_next = (rx_rp == LAST) ? '0 : rx_rp + 1'b1;
  assign tx_wp_next = (tx_wp == LAST) ? '0 : tx_wp + 1'b1;
  assign tx_rp_next = (tx_rp == LAST) ? '0 : tx_rp + 1'b1;
  assign rx_full    = (rx_wp_next == rx_rp);
  assign rx_empty   = (rx_rp == rx_wp);
  assign tx_full    = (tx_wp_next == tx_rp);
  assign tx_empty   = (tx_rp == tx_wp);

  // per-request decisions
  always_comb begin
    rx_push      = 1'b0;
    rx_pop       = 1'b0;
    tx_push      = 1'b0;
    tx_pop       = 1'b0;
    drop         = 1'b0;
    pdisc        = 1'b0;
    tx_en_next   = tx_en;
    discard_next = discard;
    unique case (req_type)
      urtrb_pkg::REQ_LINE_RX: begin
        rx_push = !rx_full;
        drop    = rx_full;
      end
      urtrb_pkg::REQ_TX_READY: begin
        if (tx_en) begin
          tx_pop     = !tx_empty;
          tx_en_next = !tx_empty;
        end
      end
      urtrb_pkg::REQ_GET: begin
        rx_pop = !rx_empty;
      end
      urtrb_pkg::REQ_PUT: begin
        priority if (data_byte == '0) begin
          discard_next = 1'b0;
          tx_en_next   = 1'b1;
        end else if (discard) begin
          pdisc = 1'b1;
        end else if (tx_full) begin
          discard_next = 1'b1;
          pdisc        = 1'b1;
        end else begin
          tx_push = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // queue memories with registered reads
  always_ff @(posedge clk) begin
    if (cmd.take && rx_push) begin
      rx_mem[rx_wp] <= data_byte;
    end
    if (cmd.take && tx_push) begin
      tx_mem[tx_wp] <= data_byte;
    end
    if (cmd.take) begin
      rx_rd <= rx_mem[rx_rp];
      tx_rd <= tx_mem[tx_rp];
    end
  end

  // pointers and mode flags
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_wp   <= '0;
      rx_rp   <= '0;
      tx_wp   <= '0;
      tx_rp   <= '0;
      tx_en   <= 1'b0;
      discard <= 1'b0;
    end else if (cmd.take) begin
      if (rx_push) rx_wp <= rx_wp_next;
      if (rx_pop)  rx_rp <= rx_rp_next;
      if (tx_push) tx_wp <= tx_wp_next;
      if (tx_pop)  tx_rp <= tx_rp_next;
      tx_en   <= tx_en_next;
      discard <= discard_next;
    end
  end

  // item flags captured at take
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pop_line <= tx_pop;
      pop_get  <= rx_pop;
      drop_r   <= drop;
      pdisc_r  <= pdisc;
      tx_en_r  <= tx_en_next;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      line_valid    <= pop_line;
      line_byte     <= pop_line ? tx_rd : '0;
      read_byte     <= pop_get ? rx_rd : '0;
      rx_dropped    <= drop_r;
      put_discarded <= pdisc_r;
      tx_enabled    <= tx_en_r;
    end
  end

  // result register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (cmd.emit) begin
      out_full <= 1'b1;
    end else if (rsp_ready) begin
      out_full <= 1'b0;
    end
  end

  assign rsp_valid       = out_full;
  assign status.out_full = out_full;

endmodule

// ----- rtl/uart_rx_tx_ring_buffers_unit.sv -----
// uart receive/transmit ring buffer pair: top level
//
// Usage: each request on the request channel is a line byte received, a
// transmitter-ready event, a get request or a put character. Every request
// yields exactly one result on the result channel, in request order.
// Both queues are QUEUE_DEPTH-slot rings holding up to QUEUE_DEPTH-1 bytes.
// Timing: a request is taken in the idle state; its queue reads and flags are
// registered, then its result is loaded into the result register from the
// execute state once that register is free. A request occupies the unit from
// take to result load, so no new request is taken before the current one has
// loaded its result; the queue memory read register lies between the two.
// Stalls: while a result waits in the result register, the next request is
// still taken; the unit only holds in its execute state until the register
// frees up, and request ready stays low meanwhile.
// Reset: rst clears pointers, transmit enable, discard mode and the result
// valid flag. Queue contents stay; no unwritten slot reaches a result.
`include "uart_rx_tx_ring_buffers_unit_defines.svh"

module uart_rx_tx_ring_buffers_unit #(
  parameter int QUEUE_DEPTH = 128
) (
  input  logic             clk,
  input  logic             rst,
  urtrb_req_if.sink        request,
  urtrb_rsp_if.source      result
);

  urtrb_pkg::cmd_t    cmd;
  urtrb_pkg::status_t status;

  // sequencing
  urtrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .rsp_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // queues and result register
  urtrb_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .req_type      (request.req_type),
    .data_byte     (request.data_byte),
    .rsp_ready     (result.ready),
    .rsp_valid     (result.valid),
    .line_valid    (result.line_valid),
    .line_byte     (result.line_byte),
    .read_byte     (result.read_byte),
    .rx_dropped    (result.rx_dropped),
    .put_discarded (result.put_discarded),
    .tx_enabled    (result.tx_enabled)
  );

  // checks
  `URTRB_ASSERT_NEXT(a_one_request_at_a_time, clk, rst, request.valid && request.ready, !request.ready, "request taken while one is in flight")
  `URTRB_ASSERT_NEXT(a_emit_fills_result, clk, rst, cmd.emit, result.valid, "result load did not show on the result channel")
  `URTRB_ASSERT_NOW(a_send_keeps_enable, clk, rst, result.valid && result.line_valid, result.tx_enabled && !result.rx_dropped && !result.put_discarded, "line byte sent with inconsistent flags")

endmodule
